/* design/i2a_pkg.sv */
// shared types, ascii codes and digit helper for the integer to text converter
package i2a_pkg;

   typedef struct packed {
      logic signed [63:0] value;
      logic [1:0]         command;
   } req_type;

   typedef struct packed {
      logic [6:0] text_char;
      logic       last;
   } rsp_type;

   localparam logic [1:0] CMD_SIGNED_DEC = 2'd0;
   localparam logic [1:0] CMD_HEX        = 2'd1;

   localparam logic [6:0] CH_MINUS   = 7'h2d;
   localparam logic [6:0] CH_ZERO    = 7'h30;
   localparam logic [6:0] CH_A_LOWER = 7'h61;

   function automatic logic [6:0] digit_char(input logic [3:0] d);
      logic [6:0] c;
      if (d < 4'd10) begin
         c = CH_ZERO + {3'b000, d};
      end else begin
         c = CH_A_LOWER + {3'b000, d} - 7'd10;
      end
      return c;
   endfunction

endpackage

/* design/i2a_bcd_step.sv */
// one double-dabble step: add-3 adjust on every bcd digit, then shift in one binary bit
module i2a_bcd_step #(
   parameter int NDIG = 20
) (
   input  logic [NDIG*4-1:0] bcd_i,
   input  logic              bit_i,
   output logic [NDIG*4-1:0] bcd_o
);
   logic [NDIG*4-1:0] adj;

   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         if (bcd_i[i*4 +: 4] >= 4'd5) begin
            adj[i*4 +: 4] = bcd_i[i*4 +: 4] + 4'd3;
         end else begin
            adj[i*4 +: 4] = bcd_i[i*4 +: 4];
         end
      end
      bcd_o = {adj[NDIG*4-2:0], bit_i};
   end

endmodule

/* design/int64_to_ascii_digits.sv */
// top level: integer to ascii text converter, signed/unsigned decimal or hexadecimal
//
// usage
//   request channel req_valid / req_stall / req_data carries value and command
//   (0 signed decimal, 1 lower-case hex, any other code unsigned decimal);
//   only the low VALUE_WIDTH bits of value are used
//   response channel rsp_valid / rsp_stall / rsp_data gives one ascii character
//   per transfer, most significant first, last set on the final character
//   one request at a time: req_stall stays high from acceptance until the
//   last character has been loaded into the output register
//   decimal: the bit-serial double-dabble loop shifts in all VALUE_WIDTH bits,
//   then leading zero digits are dropped (the last digit always stays), then
//   the characters go out (sign first, if any); dropped digits plus digit
//   characters always fill the NSLOT digit slots, 20 at VALUE_WIDTH = 64
//   hex: no conversion loop, leading zero skip then the characters
//   a stalled response holds the output register and pauses the sequencer in its sign and emit states
//   reset clears the sequencer and the response valid; nothing else is cleared
module int64_to_ascii_digits #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  i2a_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output i2a_pkg::rsp_type rsp_data
);
   import i2a_pkg::*;

   localparam int NDIG  = (VALUE_WIDTH * 1233) / 4096 + 1;
   localparam int NHEX  = (VALUE_WIDTH + 3) / 4;
   localparam int NSLOT = (NDIG > NHEX) ? NDIG : NHEX;
   localparam int DIG_W = NSLOT * 4;
   localparam int CNT_W = $clog2(NSLOT + 1);
   localparam int BIT_W = $clog2(VALUE_WIDTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_SIGN,
      ST_EMIT
   } state_type;

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [DIG_W-1:0]       dig_ff, dig_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [BIT_W-1:0]       bit_cnt_ff, bit_cnt_in;
   logic                   minus_ff, minus_in;
   logic                   hex_ff, hex_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [VALUE_WIDTH-1:0] raw;
   logic [VALUE_WIDTH-1:0] neg;
   logic [NDIG*4-1:0]      bcd_next;
   logic [3:0]             top_digit;
   logic                   out_free;
   logic                   accept;

   assign raw       = req_data.value[VALUE_WIDTH-1:0];
   assign neg       = ~raw + {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
   assign top_digit = dig_ff[DIG_W-1 -: 4];
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && (state_ff == ST_IDLE);

   i2a_bcd_step #(
      .NDIG (NDIG)
   ) u_bcd_step (
      .bcd_i (dig_ff[NDIG*4-1:0]),
      .bit_i (bin_ff[VALUE_WIDTH-1]),
      .bcd_o (bcd_next)
   );

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      dig_in       = dig_ff;
      cnt_in       = cnt_ff;
      bit_cnt_in   = bit_cnt_ff;
      minus_in     = minus_ff;
      hex_in       = hex_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               hex_in     = (req_data.command == CMD_HEX);
               minus_in   = (req_data.command == CMD_SIGNED_DEC) && raw[VALUE_WIDTH-1];
               bit_cnt_in = BIT_W'(VALUE_WIDTH);
               cnt_in     = CNT_W'(NSLOT);
               if (req_data.command == CMD_HEX) begin
                  dig_in   = DIG_W'(raw);
                  state_in = ST_SKIP;
               end else begin
                  bin_in   = ((req_data.command == CMD_SIGNED_DEC) && raw[VALUE_WIDTH-1])
                             ? neg : raw;
                  dig_in   = '0;
                  state_in = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            dig_in     = DIG_W'(bcd_next);
            bin_in     = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == BIT_W'(1)) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if ((top_digit == 4'd0) && (cnt_ff != CNT_W'(1))) begin
               dig_in = {dig_ff[DIG_W-5:0], 4'd0};
               cnt_in = cnt_ff - 1'b1;
            end else if (minus_ff) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.text_char = CH_MINUS;
               rsp_in.last      = 1'b0;
               state_in         = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.text_char = digit_char(top_digit);
               rsp_in.last      = (cnt_ff == CNT_W'(1));
               dig_in           = {dig_ff[DIG_W-5:0], 4'd0};
               cnt_in           = cnt_ff - 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bin_ff     <= bin_in;
      dig_ff     <= dig_in;
      cnt_ff     <= cnt_in;
      bit_cnt_ff <= bit_cnt_in;
      minus_ff   <= minus_in;
      hex_ff     <= hex_in;
      rsp_ff     <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // busy straight after a request is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("request accepted but converter not busy");

   // remaining character count never runs out while digits are pending
   a_cnt_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SKIP || state_ff == ST_EMIT) |-> (cnt_ff != '0))
      else $error("digit count empty during skip or emit");

   // double-dabble must leave only decimal digits
   a_bcd_digit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !hex_ff) |-> (top_digit <= 4'd9))
      else $error("non-decimal digit in bcd result");

   // the sign is never the final character
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.text_char == CH_MINUS) |-> !rsp_data.last)
      else $error("minus sign marked as last character");

endmodule

/* bench/int64_to_ascii_digits_checker.sv */
// checker for the integer to text converter: predicts the characters of each request and compares
module int64_to_ascii_digits_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  i2a_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  i2a_pkg::rsp_type rsp_data,
   output int               failures,
   output int               chars_pending,
   output int               chars_checked
);
   import i2a_pkg::*;

   rsp_type expected_text [$];
   rsp_type want;
   string   digit_glyphs = "0123456789abcdef";

   initial begin
      failures      = 0;
      chars_pending = 0;
      chars_checked = 0;
   end

   function automatic void queue_number_text(input req_type number);
      logic [63:0] mag;
      logic [63:0] radix;
      logic [6:0]  digit_text [0:20];
      int          count;
      logic        minus;
      mag   = number.value;
      radix = (number.command == CMD_HEX) ? 64'd16 : 64'd10;
      minus = 1'b0;
      count = 0;
      if (number.command == CMD_SIGNED_DEC && mag[63]) begin
         minus = 1'b1;
         mag   = ~mag + 64'd1;
      end
      do begin
         digit_text[count] = 7'(digit_glyphs[int'(mag % radix)]);
         count++;
         mag = mag / radix;
      end while (mag != 64'd0);
      if (minus) begin
         expected_text.push_back(rsp_type'{text_char: CH_MINUS, last: 1'b0});
      end
      for (int i = count - 1; i >= 0; i--) begin
         expected_text.push_back(rsp_type'{text_char: digit_text[i], last: (i == 0)});
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            chars_checked++;
            if (expected_text.size() == 0) begin
               $error("unexpected character %h with nothing outstanding", rsp_data.text_char);
               failures++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_data.text_char !== want.text_char) begin
                  $error("text_char: expected %h, got %h", want.text_char, rsp_data.text_char);
                  failures++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %b, got %b", want.last, rsp_data.last);
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            queue_number_text(req_data);
         end
      end
      chars_pending = expected_text.size();
   end

endmodule

/* bench/int64_to_ascii_digits_tb.sv */
// testbench top for the integer to text converter: stimulus, stalls and verdict
module int64_to_ascii_digits_tb;
   import i2a_pkg::*;

   localparam logic [1:0] CMD_UNSIGNED_DEC = 2'd2;
   localparam logic [1:0] CMD_UNSIGNED_ALT = 2'd3;
   localparam int RANDOM_NUMBERS = 438;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 200;
   localparam int CYCLE_LIMIT    = 500000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int   failures;
   int   chars_pending;
   int   chars_checked;
   int   cycle_count    = 0;
   int   per_command[4] = '{default: 0};
   logic quiet          = 1'b0;
   logic hold_request   = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   int64_to_ascii_digits uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   int64_to_ascii_digits_checker text_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .failures      (failures),
      .chars_pending (chars_pending),
      .chars_checked (chars_checked)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[int64_to_ascii_digits] ERROR");
         $finish;
      end
   end

   // response side: short stall bursts, calm stretches, one long hold-off on request
   initial begin
      int pick;
      forever begin
         @(negedge clock);
         pick = $urandom_range(0, 15);
         if (hold_request) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall    = 1'b0;
            hold_request = 1'b0;
         end else if (!quiet && pick < 4) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 5)) @(negedge clock);
            rsp_stall = 1'b0;
         end else if (pick == 4) begin
            repeat ($urandom_range(20, 60)) @(negedge clock);
         end
      end
   end

   task automatic offer_number(input logic [63:0] value, input logic [1:0] command);
      req_data  = '{value: value, command: command};
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      per_command[command]++;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
   endtask

   task automatic await_all_text();
      req_valid = 1'b0;
      do @(negedge clock); while (chars_pending != 0);
   endtask

   function automatic logic [63:0] random_value();
      logic [63:0] v;
      logic [63:0] p;
      p = 64'd1;
      case ($urandom_range(0, 5))
         0: v = {$urandom, $urandom};
         1: v = 64'($urandom_range(0, 999));
         2: v = -64'($urandom_range(1, 999));
         3: v = {$urandom, $urandom} >> $urandom_range(1, 63);
         4: v = ~({$urandom, $urandom} >> $urandom_range(1, 63));
         default: begin
            repeat ($urandom_range(0, 19)) p = p * 64'd10;
            v = p - 64'($urandom_range(0, 1));
         end
      endcase
      return v;
   endfunction

   initial begin
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // zero under every code, the sign boundaries, digit roll-overs and widest texts
      offer_number(64'd0, CMD_SIGNED_DEC);
      offer_number(64'd0, CMD_HEX);
      offer_number(64'd0, CMD_UNSIGNED_DEC);
      offer_number(64'd0, CMD_UNSIGNED_ALT);
      offer_number(64'd1, CMD_SIGNED_DEC);
      offer_number(64'hffff_ffff_ffff_ffff, CMD_SIGNED_DEC);
      offer_number(64'hffff_ffff_ffff_ffff, CMD_HEX);
      offer_number(64'hffff_ffff_ffff_ffff, CMD_UNSIGNED_DEC);
      offer_number(64'hffff_ffff_ffff_ffff, CMD_UNSIGNED_ALT);
      offer_number(64'h8000_0000_0000_0000, CMD_SIGNED_DEC);
      offer_number(64'h8000_0000_0000_0000, CMD_HEX);
      offer_number(64'h8000_0000_0000_0000, CMD_UNSIGNED_DEC);
      offer_number(64'h7fff_ffff_ffff_ffff, CMD_SIGNED_DEC);
      offer_number(64'h7fff_ffff_ffff_ffff, CMD_HEX);
      offer_number(64'd9, CMD_SIGNED_DEC);
      offer_number(64'd10, CMD_SIGNED_DEC);
      offer_number(64'd15, CMD_HEX);
      offer_number(64'd16, CMD_HEX);
      offer_number(64'h0123_4567_89ab_cdef, CMD_HEX);
      offer_number(64'd10000000000000000000, CMD_UNSIGNED_DEC);
      offer_number(-64'd123, CMD_UNSIGNED_ALT);
      offer_number(-64'd123, CMD_SIGNED_DEC);
      await_all_text();

      for (int n = 0; n < RANDOM_NUMBERS; n++) begin
         if (n == 120) begin
            hold_request = 1'b1;
         end
         if (n == 250) begin
            await_all_text();
         end
         if (n == RANDOM_NUMBERS - 60) begin
            quiet = 1'b1;
         end
         offer_number(random_value(), 2'($urandom_range(0, 3)));
      end

      await_all_text();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("converted %0d numbers: %0d signed decimal, %0d hex, %0d unsigned, %0d spare code",
               per_command[0] + per_command[1] + per_command[2] + per_command[3],
               per_command[0], per_command[1], per_command[2], per_command[3]);
      $display("%0d characters compared, with a long response hold-off and full drains",
               chars_checked);
      if (failures == 0) begin
         $display("[int64_to_ascii_digits] OK");
      end else begin
         $display("[int64_to_ascii_digits] ERROR");
      end
      $finish;
   end

endmodule
